// ----- rtl/core/e2c_pkg.sv -----
// Shared types and constants for the epoch seconds to calendar converter.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package e2c_pkg;

  // conversion constants
  localparam int unsigned SEC_PER_MIN    = 60;
  localparam int unsigned HOURS_PER_QUAD = 1461 * 24;
  localparam int unsigned HOURS_PER_YEAR = 8760;
  localparam int unsigned HOURS_PER_DAY  = 24;
  localparam int unsigned BASE_YEAR      = 1970;
  localparam int unsigned FEB29_DOY      = 60;
  localparam int unsigned LAST_MONTH_IDX = 11;
  localparam int unsigned YEAR_STEPS     = 3;

  // reciprocals: floor(x / d) == (x * m) >> s over the operand range in use
  localparam logic [31:0] RCP_MIN  = 32'h8888_8889;  // d = 60, s = 37, any 32-bit x
  localparam int unsigned SHR_MIN  = 37;
  localparam logic [31:0] RCP_QUAD = 32'd1959830;    // d = 35064, s = 36, x below 2^21
  localparam int unsigned SHR_QUAD = 36;
  localparam logic [31:0] RCP_DAY  = 32'hAAAA_AAAB;  // d = 24, s = 36, any 32-bit x
  localparam int unsigned SHR_DAY  = 36;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SEC,
    ST_SPLIT_SEC,
    ST_MUL_MIN,
    ST_SPLIT_MIN,
    ST_MUL_QUAD,
    ST_SPLIT_QUAD,
    ST_YEAR,
    ST_MUL_DAY,
    ST_MPREP,
    ST_MWALK,
    ST_DONE
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_MUL_MIN,
    OP_SPLIT_SEC,
    OP_SPLIT_MIN,
    OP_MUL_QUAD,
    OP_SPLIT_QUAD,
    OP_YEAR,
    OP_MUL_DAY,
    OP_MPREP,
    OP_MWALK
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } status_t;

  // days in each month of a common year, index 0 is january
  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] len;
    case (idx)
      4'd1:    len = 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/e2c_ctrl.sv -----
// Sequencing state machine of the epoch seconds to calendar converter.
// Depends on e2c_pkg; drives datapath commands and reads its status.
`timescale 1ns / 1ps

module e2c_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  e2c_pkg::status_t status,
  output e2c_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);

  localparam logic [1:0] YR_LAST = 2'(e2c_pkg::YEAR_STEPS - 1);

  e2c_pkg::state_t state_r, state_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= e2c_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      e2c_pkg::ST_IDLE: begin
        if (start) state_nxt = e2c_pkg::ST_MUL_SEC;
      end
      e2c_pkg::ST_MUL_SEC:   state_nxt = e2c_pkg::ST_SPLIT_SEC;
      e2c_pkg::ST_SPLIT_SEC: state_nxt = e2c_pkg::ST_MUL_MIN;
      e2c_pkg::ST_MUL_MIN:   state_nxt = e2c_pkg::ST_SPLIT_MIN;
      e2c_pkg::ST_SPLIT_MIN: state_nxt = e2c_pkg::ST_MUL_QUAD;
      e2c_pkg::ST_MUL_QUAD:  state_nxt = e2c_pkg::ST_SPLIT_QUAD;
      e2c_pkg::ST_SPLIT_QUAD: begin
        state_nxt = e2c_pkg::ST_YEAR;
        cnt_nxt   = YR_LAST;
      end
      e2c_pkg::ST_YEAR: begin
        cnt_nxt = cnt_r - 2'd1;
        if (cnt_r == '0) state_nxt = e2c_pkg::ST_MUL_DAY;
      end
      e2c_pkg::ST_MUL_DAY: state_nxt = e2c_pkg::ST_MPREP;
      e2c_pkg::ST_MPREP:   state_nxt = e2c_pkg::ST_MWALK;
      e2c_pkg::ST_MWALK: begin
        if (status.walk_done) state_nxt = e2c_pkg::ST_DONE;
      end
      e2c_pkg::ST_DONE: state_nxt = e2c_pkg::ST_IDLE;
      default: state_nxt = e2c_pkg::ST_IDLE;
    endcase
  end

  // command and handshake outputs
  always_comb begin
    cmd.op = e2c_pkg::OP_NONE;
    busy   = 1'b1;
    done   = 1'b0;
    case (state_r)
      e2c_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = e2c_pkg::OP_START;
      end
      e2c_pkg::ST_MUL_SEC:    cmd.op = e2c_pkg::OP_MUL_MIN;
      e2c_pkg::ST_SPLIT_SEC:  cmd.op = e2c_pkg::OP_SPLIT_SEC;
      e2c_pkg::ST_MUL_MIN:    cmd.op = e2c_pkg::OP_MUL_MIN;
      e2c_pkg::ST_SPLIT_MIN:  cmd.op = e2c_pkg::OP_SPLIT_MIN;
      e2c_pkg::ST_MUL_QUAD:   cmd.op = e2c_pkg::OP_MUL_QUAD;
      e2c_pkg::ST_SPLIT_QUAD: cmd.op = e2c_pkg::OP_SPLIT_QUAD;
      e2c_pkg::ST_YEAR:       cmd.op = e2c_pkg::OP_YEAR;
      e2c_pkg::ST_MUL_DAY:    cmd.op = e2c_pkg::OP_MUL_DAY;
      e2c_pkg::ST_MPREP:      cmd.op = e2c_pkg::OP_MPREP;
      e2c_pkg::ST_MWALK:      cmd.op = e2c_pkg::OP_MWALK;
      e2c_pkg::ST_DONE:       done   = 1'b1;
      default:                cmd.op = e2c_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- rtl/core/e2c_datapath.sv -----
// Datapath of the epoch seconds to calendar converter: shared reciprocal
// multiplier, year reduction and month walk. Depends on e2c_pkg.
`timescale 1ns / 1ps

module e2c_datapath (
  input  logic             clk,
  input  e2c_pkg::cmd_t    cmd,
  input  logic [31:0]      in_epoch_seconds,
  output e2c_pkg::status_t status,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second
);

  localparam logic [31:0] D_MIN  = 32'(e2c_pkg::SEC_PER_MIN);
  localparam logic [31:0] D_QUAD = 32'(e2c_pkg::HOURS_PER_QUAD);
  localparam logic [15:0] D_DAY  = 16'(e2c_pkg::HOURS_PER_DAY);
  localparam logic [15:0] YH     = 16'(e2c_pkg::HOURS_PER_YEAR);
  localparam logic [11:0] BASE   = 12'(e2c_pkg::BASE_YEAR);
  localparam logic [8:0]  FEB29  = 9'(e2c_pkg::FEB29_DOY);
  localparam logic [3:0]  LASTM  = 4'(e2c_pkg::LAST_MONTH_IDX);

  // value being split, registered product and hours left in the block
  logic [31:0] x_r, x_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [15:0] r_r, r_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hr_r, hr_nxt;
  logic [11:0] year_r, year_nxt;
  logic [8:0]  doy_r, doy_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic        feb29_r, feb29_nxt;

  logic [31:0] mul_a;
  logic [31:0] rcp;
  logic [63:0] mul_p;
  logic [31:0] quo_min, rem_min;
  logic [31:0] quo_quad, rem_quad;
  logic [15:0] quo_day, rem_day;
  logic        leap;
  logic [15:0] yh;
  logic [8:0]  doy1;
  logic [8:0]  mlen;

  // reciprocal multiplier operands
  always_comb begin
    mul_a = x_r;
    rcp   = e2c_pkg::RCP_MIN;
    case (cmd.op)
      e2c_pkg::OP_MUL_QUAD: rcp = e2c_pkg::RCP_QUAD;
      e2c_pkg::OP_MUL_DAY: begin
        mul_a = {16'b0, r_r};
        rcp   = e2c_pkg::RCP_DAY;
      end
      default: rcp = e2c_pkg::RCP_MIN;
    endcase
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, rcp};

  // quotients from the product, remainders by constant multiply and subtract
  assign quo_min  = 32'(prod_r >> e2c_pkg::SHR_MIN);
  assign rem_min  = x_r - quo_min * D_MIN;
  assign quo_quad = 32'(prod_r >> e2c_pkg::SHR_QUAD);
  assign rem_quad = x_r - quo_quad * D_QUAD;
  assign quo_day  = 16'(prod_r >> e2c_pkg::SHR_DAY);
  assign rem_day  = r_r - quo_day * D_DAY;

  assign leap = (year_r[1:0] == 2'b00);
  assign yh   = leap ? (YH + D_DAY) : YH;
  assign doy1 = quo_day[8:0] + 9'd1;
  assign mlen = {4'b0, e2c_pkg::month_len(mon_r)};

  assign status.walk_done = feb29_r || (mon_r == LASTM) || (doy_r <= mlen);

  // operation select
  always_comb begin
    x_nxt     = x_r;
    prod_nxt  = prod_r;
    r_nxt     = r_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hr_nxt    = hr_r;
    year_nxt  = year_r;
    doy_nxt   = doy_r;
    mon_nxt   = mon_r;
    feb29_nxt = feb29_r;
    case (cmd.op)
      e2c_pkg::OP_START: begin
        x_nxt = in_epoch_seconds;
      end
      e2c_pkg::OP_MUL_MIN, e2c_pkg::OP_MUL_QUAD, e2c_pkg::OP_MUL_DAY: begin
        prod_nxt = mul_p;
      end
      e2c_pkg::OP_SPLIT_SEC: begin
        sec_nxt = rem_min[5:0];
        x_nxt   = quo_min;
      end
      e2c_pkg::OP_SPLIT_MIN: begin
        min_nxt = rem_min[5:0];
        x_nxt   = quo_min;
      end
      e2c_pkg::OP_SPLIT_QUAD: begin
        // whole four-year blocks, remainder kept in r as hours
        year_nxt = BASE + {4'b0, quo_quad[5:0], 2'b00};
        r_nxt    = rem_quad[15:0];
      end
      e2c_pkg::OP_YEAR: begin
        if (r_r >= yh) begin
          r_nxt    = r_r - yh;
          year_nxt = year_r + 12'd1;
        end
      end
      e2c_pkg::OP_MPREP: begin
        hr_nxt = rem_day[4:0];
        if (leap && (doy1 == FEB29)) begin
          feb29_nxt = 1'b1;
          mon_nxt   = 4'd1;
          doy_nxt   = 9'd29;
        end else begin
          feb29_nxt = 1'b0;
          mon_nxt   = 4'd0;
          doy_nxt   = (leap && (doy1 > FEB29)) ? (doy1 - 9'd1) : doy1;
        end
      end
      e2c_pkg::OP_MWALK: begin
        if (!status.walk_done) begin
          doy_nxt = doy_r - mlen;
          mon_nxt = mon_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    prod_r  <= prod_nxt;
    r_r     <= r_nxt;
    sec_r   <= sec_nxt;
    min_r   <= min_nxt;
    hr_r    <= hr_nxt;
    year_r  <= year_nxt;
    doy_r   <= doy_nxt;
    mon_r   <= mon_nxt;
    feb29_r <= feb29_nxt;
  end

  // result fields
  assign out_year   = year_r;
  assign out_month  = mon_r + 4'd1;
  assign out_day    = doy_r[4:0];
  assign out_hour   = hr_r;
  assign out_minute = min_r;
  assign out_second = sec_r;

endmodule

// ----- rtl/core/epoch_seconds_to_calendar_core.sv -----
// Top level of the epoch seconds to calendar converter.
// Depends on e2c_pkg, e2c_ctrl and e2c_datapath.
`timescale 1ns / 1ps

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00
// into year, month, day, hour, minute and second, treating every year
// divisible by four as a leap year. A request is taken when start is high
// and busy is low; busy then stays high until the result has been shown.
// The result is on the out_ ports for exactly one cycle with out_valid
// high, and the receiver cannot stall it. A shared 32 by 32 multiplier
// applies reciprocal constants for the divisions by 60, 60, 35064 and 24,
// each a multiply step and a split step, plus three year steps, one to
// twelve month steps and the strobe. A new request is taken in the cycle
// after the strobe.
module epoch_seconds_to_calendar_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);

  e2c_pkg::cmd_t    cmd;
  e2c_pkg::status_t status;

  // sequencer
  e2c_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  // arithmetic
  e2c_datapath u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .in_epoch_seconds (in_epoch_seconds),
    .status           (status),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

endmodule

// ----- rtl/core/e2c_checker.sv -----
// Port-level assertions for the epoch seconds to calendar converter,
// bound to epoch_seconds_to_calendar_core. No package dependency.
`timescale 1ns / 1ps

module e2c_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [5:0]  out_second
);

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  // result only shows while a request is in flight, and frees the block
  a_valid_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 (!busy && !out_valid))
    else $error("strobe outside a request or block not freed");

  // busy only rises after an accepted request
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // result fields within calendar range
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 &&
                   out_day >= 5'd1 && out_day <= 5'd31 &&
                   out_hour <= 5'd23 && out_minute <= 6'd59 &&
                   out_second <= 6'd59 &&
                   out_year >= 12'd1970 && out_year <= 12'd2106))
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_core e2c_checker u_e2c_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_year   (out_year),
  .out_month  (out_month),
  .out_day    (out_day),
  .out_hour   (out_hour),
  .out_minute (out_minute),
  .out_second (out_second)
);

// ----- tb/sv/epoch_seconds_to_calendar_core_tb.sv -----
// Self-checking testbench for epoch_seconds_to_calendar_core: random and directed
// second counts are converted, and each strobed date is checked against a local predictor.
// Depends on e2c_pkg (for its conversion constants) and the core RTL.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_core_tb;

  localparam int RANDOM_REQUESTS = 950;
  localparam int DRAIN_CYCLES    = 60;
  localparam longint SEC_PER_DAY = 86400;
  // day number of 1972-01-01, the first leap year after the base year
  localparam longint FIRST_LEAP_DAY = 730;
  localparam longint DAYS_PER_QUAD  = 1461;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  typedef struct packed {
    logic [31:0] secs;
    calendar_t   date;
  } pending_date_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  logic [31:0]   epoch_requests[$];
  pending_date_t expected_dates[$];
  logic          req_taken = 1'b0;
  int            error_count = 0;
  int            idle_left = 0;
  int            calm_left = 0;
  bit            idle_while_busy = 1'b0;

  epoch_seconds_to_calendar_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

  always #1 clk = ~clk;

  // length of a month in a common year, 0 is january
  function automatic int unsigned days_in_month(input int unsigned idx);
    int unsigned n;
    case (idx)
      1:          n = 28;
      3, 5, 8, 10: n = 30;
      default:    n = 31;
    endcase
    return n;
  endfunction

  // every year divisible by four counts as leap, 2100 included
  function automatic calendar_t epoch_to_calendar(input logic [31:0] secs);
    int unsigned t, yr, doy, mi, year_hours;
    bit          leap;
    calendar_t   c;
    c.second = 6'(secs % e2c_pkg::SEC_PER_MIN);
    t = secs / e2c_pkg::SEC_PER_MIN;
    c.minute = 6'(t % e2c_pkg::SEC_PER_MIN);
    t = t / e2c_pkg::SEC_PER_MIN;
    yr = (t / e2c_pkg::HOURS_PER_QUAD) * 4 + e2c_pkg::BASE_YEAR;
    t = t % e2c_pkg::HOURS_PER_QUAD;
    // peel off up to three whole years inside the four-year block
    repeat (3) begin
      year_hours = e2c_pkg::HOURS_PER_YEAR + ((yr % 4 == 0) ? e2c_pkg::HOURS_PER_DAY : 0);
      if (t >= year_hours) begin
        t = t - year_hours;
        yr = yr + 1;
      end
    end
    c.hour = 5'(t % e2c_pkg::HOURS_PER_DAY);
    doy = t / e2c_pkg::HOURS_PER_DAY + 1;
    leap = (yr % 4 == 0);
    c.year = 12'(yr);
    if (leap && doy == e2c_pkg::FEB29_DOY) begin
      c.month = 4'd2;
      c.day = 5'd29;
    end else begin
      if (leap && doy > e2c_pkg::FEB29_DOY) doy = doy - 1;
      mi = 0;
      while (mi < 11 && doy > days_in_month(mi)) begin
        doy = doy - days_in_month(mi);
        mi = mi + 1;
      end
      c.month = 4'(mi + 1);
      c.day = 5'(doy);
    end
    return c;
  endfunction

  // second counts clustered on day, year and leap-day edges and near the 32-bit end, plus uniform noise
  function automatic logic [31:0] random_epoch();
    longint      v, quad_day;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    quad_day = FIRST_LEAP_DAY + DAYS_PER_QUAD * $urandom_range(0, 33);
    case (kind)
      4, 5: begin
        v = SEC_PER_DAY * $urandom_range(0, 49710);
        case ($urandom_range(0, 2))
          0:       v = v + SEC_PER_DAY - 1;
          1:       v = v + $urandom_range(0, 86399);
          default: v = v;
        endcase
      end
      6, 7: begin
        // around 29 february of a leap year
        v = (quad_day + 59) * SEC_PER_DAY;
        v = v + longint'($urandom_range(0, 4 * 86400)) - 2 * SEC_PER_DAY;
      end
      8: begin
        // around new year inside a four-year block
        case ($urandom_range(0, 3))
          0:       v = quad_day;
          1:       v = quad_day + 366;
          2:       v = quad_day + 731;
          default: v = quad_day + 1096;
        endcase
        v = v * SEC_PER_DAY + longint'($urandom_range(0, 7200)) - 3600;
      end
      9: v = 64'hFFFF_FFFF - $urandom_range(0, 32'h0400_0000);
      default: v = $urandom;
    endcase
    if (v < 0 || v > 64'hFFFF_FFFF) v = $urandom;
    return v[31:0];
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got,
                             input logic [31:0] secs);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch for %0d s: expected %0d, got %0d", $time, name, secs, want, got);
    end
  endtask

  // request driver, changes inputs on the falling edge
  always @(negedge clk) begin : drive_requests
    logic        nxt_start;
    logic [31:0] nxt_secs;
    int unsigned r;
    nxt_start = start;
    nxt_secs = in_epoch_seconds;
    if (rst_n && !(start && !req_taken)) begin
      nxt_start = 1'b0;
      if (idle_left > 0) begin
        if (!busy || idle_while_busy) idle_left--;
        nxt_secs = $urandom;
      end else if (epoch_requests.size() != 0) begin
        nxt_start = 1'b1;
        nxt_secs = epoch_requests.pop_front();
        // gap before the next request, counted after this one is taken
        r = $urandom_range(0, 99);
        idle_while_busy = $urandom_range(0, 1);
        if (calm_left > 0) begin
          calm_left--;
          idle_left = 0;
        end else if (r < 5) begin
          calm_left = $urandom_range(10, 40);
          idle_left = 0;
        end else if (r < 45) begin
          idle_left = 0;
        end else if (r < 85) begin
          idle_left = $urandom_range(1, 3);
        end else if (r < 97) begin
          idle_left = $urandom_range(4, 20);
        end else begin
          idle_left = $urandom_range(40, 150);
        end
      end
    end
    start <= nxt_start;
    in_epoch_seconds <= nxt_secs;
  end

  // result checker and request capture on the rising edge
  always @(posedge clk) begin : check_results
    pending_date_t want;
    if (rst_n && out_valid) begin
      if (expected_dates.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d", $time, out_year, out_month,
                 out_day, out_hour, out_minute, out_second);
      end else begin
        want = expected_dates.pop_front();
        check_field("year", 32'(want.date.year), 32'(out_year), want.secs);
        check_field("month", 32'(want.date.month), 32'(out_month), want.secs);
        check_field("day", 32'(want.date.day), 32'(out_day), want.secs);
        check_field("hour", 32'(want.date.hour), 32'(out_hour), want.secs);
        check_field("minute", 32'(want.date.minute), 32'(out_minute), want.secs);
        check_field("second", 32'(want.date.second), 32'(out_second), want.secs);
      end
    end
    if (rst_n && start && !busy) begin
      want.secs = in_epoch_seconds;
      want.date = epoch_to_calendar(in_epoch_seconds);
      expected_dates.push_back(want);
    end
    req_taken <= rst_n && start && !busy;
  end

  initial begin
    // directed: extremes, unit rollovers, leap days, 2100 and the 32-bit end
    epoch_requests.push_back(32'd0);
    epoch_requests.push_back(32'hFFFF_FFFF);
    epoch_requests.push_back(32'hFFFF_FFFE);
    epoch_requests.push_back(32'd59);
    epoch_requests.push_back(32'd60);
    epoch_requests.push_back(32'd3599);
    epoch_requests.push_back(32'd86399);
    epoch_requests.push_back(32'd86400);
    epoch_requests.push_back(32'd2678399);
    epoch_requests.push_back(32'd68169599);
    epoch_requests.push_back(32'd68169600);
    epoch_requests.push_back(32'd68255999);
    epoch_requests.push_back(32'd68256000);
    epoch_requests.push_back(32'd94694399);
    epoch_requests.push_back(32'd94694400);
    epoch_requests.push_back(32'd946684799);
    epoch_requests.push_back(32'd951782400);
    epoch_requests.push_back(32'd2147483647);
    epoch_requests.push_back(32'd2147483648);
    epoch_requests.push_back(32'd4107455999);
    epoch_requests.push_back(32'd4107542399);
    epoch_requests.push_back(32'd4107542400);
    epoch_requests.push_back(32'd4107628800);
    epoch_requests.push_back(32'hAAAA_AAAA);
    epoch_requests.push_back(32'h5555_5555);
    repeat (RANDOM_REQUESTS) epoch_requests.push_back(random_epoch());

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (epoch_requests.size() != 0 || start || expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("epoch_seconds_to_calendar_core_tb: clean");
    end else begin
      $display("epoch_seconds_to_calendar_core_tb: errors");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("epoch_seconds_to_calendar_core_tb: errors");
    $finish;
  end

endmodule
